[sv/worst_fit_coalescing_allocator_core_macros.svh]
// Assertion macros for the worst-fit allocator core.
`ifndef WORST_FIT_COALESCING_ALLOCATOR_CORE_MACROS_SVH
`define WORST_FIT_COALESCING_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication under reset.
`define WFCA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication under reset.
`define WFCA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define WFCA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define WFCA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

[sv/wfca_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfca_pkg
// Shared constants, word layouts and sequencer states of the allocator.
// ----------------------------------------------------------------------------
package wfca_pkg;

    localparam int REQUESTS  = 1024;
    localparam int SEGMENTS  = 2048;
    localparam int SEG_AW    = $clog2(SEGMENTS);
    localparam int REC_AW    = $clog2(REQUESTS);
    localparam int CLR_DEPTH = (SEGMENTS > REQUESTS) ? SEGMENTS : REQUESTS;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam int AW        = 33;
    localparam logic [AW-1:0] MEM_RESET = 33'd4096;

    typedef struct packed {
        logic          valid;
        logic [AW-1:0] start;
        logic [AW-1:0] len;
    } seg_word_t;

    typedef struct packed {
        logic          valid;
        logic [AW-1:0] start;
        logic [AW-1:0] size;
    } rec_word_t;

    typedef struct packed {
        logic              clear;
        logic              feed;
        logic [SEG_AW-1:0] idx;
    } scan_ctl_t;

    typedef struct packed {
        logic              best_found;
        logic [SEG_AW-1:0] best_idx;
        logic [AW-1:0]     best_start;
        logic [AW-1:0]     best_len;
        logic              left_found;
        logic [SEG_AW-1:0] left_idx;
        logic [AW-1:0]     left_start;
        logic [AW-1:0]     left_len;
        logic              right_found;
        logic [SEG_AW-1:0] right_idx;
        logic [AW-1:0]     right_len;
        logic              slot_found;
        logic [SEG_AW-1:0] slot_idx;
    } scan_res_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REC,
        ST_SCAN,
        ST_DRAIN,
        ST_WB1,
        ST_WB2,
        ST_DONE
    } state_t;

endpackage

[sv/wfca_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfca channel interfaces
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface wfca_req_if;
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic [wfca_pkg::AW-1:0] request_size;
    logic [9:0]              handle;
    modport source (output valid, func, request_size, handle, input ready);
    modport sink (input valid, func, request_size, handle, output ready);
endinterface

interface wfca_rsp_if;
    logic                    valid;
    logic                    ready;
    logic                    granted;
    logic [wfca_pkg::AW-1:0] start_address;
    modport source (output valid, granted, start_address, input ready);
    modport sink (input valid, granted, start_address, output ready);
endinterface

interface wfca_cfg_if;
    logic                    valid;
    logic                    ready;
    logic [wfca_pkg::AW-1:0] memory_size;
    modport source (output valid, memory_size, input ready);
    modport sink (input valid, memory_size, output ready);
endinterface

[sv/worst_fit_coalescing_allocator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// worst_fit_coalescing_allocator_core
// Worst-fit cell allocator with a free segment table and coalescing frees.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per request: func 0 allocates request_size cells,
//   func 1 frees the block granted to an earlier request named by handle.
//   Every request takes the next handle from a wrapping counter.
//   rsp carries one item per allocate (granted, start_address); frees give
//   no response.
//   cfg writes memory_size; it reloads the table as one segment starting at
//   cell 1 and clears every record and the counter.
// Sequence:
//   An allocate runs from accept to response through one record read, one
//   pass over the segment RAM at one entry per cycle, a drain step, a
//   write-back and a completion step. A free runs the same steps with a
//   second write-back in place of the completion, or ends after the record read
//   when its record is not valid; req is ready again in the cycle after. One item is in flight at a time.
// Reset and stall:
//   After reset and after every cfg write a clearing pass sweeps both RAMs;
//   req stays not ready meanwhile, cfg stays ready.
//   A response waits in its output register until rsp.ready; an allocate
//   waits in its completion step until the register is empty.
// ----------------------------------------------------------------------------
`include "worst_fit_coalescing_allocator_core_macros.svh"

module worst_fit_coalescing_allocator_core (
    input  logic             clk,
    input  logic             rst_n,
    wfca_req_if.sink         req,
    wfca_rsp_if.source       rsp,
    wfca_cfg_if.sink         cfg
);

    localparam int SEG_AW = wfca_pkg::SEG_AW;
    localparam int REC_AW = wfca_pkg::REC_AW;
    localparam int CLR_W  = wfca_pkg::CLR_W;
    localparam int AW     = wfca_pkg::AW;

    wfca_pkg::state_t state_reg, state_next;

    logic [CLR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [SEG_AW-1:0] scan_cnt_reg, scan_cnt_next;
    logic              feed_reg;
    logic [SEG_AW-1:0] feed_idx_reg;
    logic [REC_AW-1:0] reqcnt_reg, reqcnt_next;
    logic [REC_AW-1:0] h_reg, h_next;
    logic              func_reg, func_next;
    logic [AW-1:0]     size_reg, size_next;
    logic [9:0]        handle_reg, handle_next;
    logic [AW-1:0]     bstart_reg, bstart_next;
    logic [AW-1:0]     bsize_reg, bsize_next;
    logic [AW-1:0]     memsize_reg;
    logic              granted_reg, granted_next;
    logic [AW-1:0]     gstart_reg, gstart_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_granted_reg, out_granted_next;
    logic [AW-1:0]     out_start_reg, out_start_next;

    // RAM ports
    logic                seg_we;
    logic [SEG_AW-1:0]   seg_waddr;
    wfca_pkg::seg_word_t seg_wdata;
    wfca_pkg::seg_word_t seg_rdata;
    logic                rec_we;
    logic [REC_AW-1:0]   rec_waddr;
    wfca_pkg::rec_word_t rec_wdata;
    wfca_pkg::rec_word_t rec_rdata;
    logic [REC_AW-1:0]   rec_raddr;

    wfca_pkg::scan_ctl_t scan_ctl;
    wfca_pkg::scan_res_t scan_res;

    logic              req_fire;
    logic              rec_ok;
    logic [AW:0]       bend;
    logic [AW+1:0]     merged_len;
    logic [AW-1:0]     merged_start;
    logic              alloc_ok;

    assign req.ready = (state_reg == wfca_pkg::ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid         = out_valid_reg;
    assign rsp.granted       = out_granted_reg;
    assign rsp.start_address = out_start_reg;

    assign rec_raddr = REC_AW'(req.handle);
    assign bend      = {1'b0, bstart_reg} + {1'b0, bsize_reg};

    // A free of its own handle sees the slot already dropped at accept.
    assign rec_ok = rec_rdata.valid && (32'(handle_reg) < wfca_pkg::REQUESTS) &&
                    (32'(handle_reg) != 32'(h_reg));

    assign merged_start = scan_res.left_found ? scan_res.left_start : bstart_reg;
    assign merged_len   = {2'b00, bsize_reg} +
                          (scan_res.left_found ? {2'b00, scan_res.left_len} : '0) +
                          (scan_res.right_found ? {2'b00, scan_res.right_len} : '0);
    assign alloc_ok     = (size_reg != '0) && scan_res.best_found &&
                          (scan_res.best_len >= size_reg);

    assign scan_ctl.clear = (state_reg == wfca_pkg::ST_REC);
    assign scan_ctl.feed  = feed_reg;
    assign scan_ctl.idx   = feed_idx_reg;

    wfca_ram #(
        .WIDTH ($bits(wfca_pkg::seg_word_t)),
        .DEPTH (wfca_pkg::SEGMENTS)
    ) u_seg_ram (
        .clk   (clk),
        .we    (seg_we),
        .waddr (seg_waddr),
        .wdata (seg_wdata),
        .raddr (scan_cnt_reg),
        .rdata (seg_rdata)
    );

    wfca_ram #(
        .WIDTH ($bits(wfca_pkg::rec_word_t)),
        .DEPTH (wfca_pkg::REQUESTS)
    ) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (rec_wdata),
        .raddr (rec_raddr),
        .rdata (rec_rdata)
    );

    wfca_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (scan_ctl),
        .entry  (seg_rdata),
        .bstart ({1'b0, bstart_reg}),
        .bend   (bend),
        .res    (scan_res)
    );

    // Sequencer: next state, RAM writes and response register.
    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        scan_cnt_next    = scan_cnt_reg;
        reqcnt_next      = reqcnt_reg;
        h_next           = h_reg;
        func_next        = func_reg;
        size_next        = size_reg;
        handle_next      = handle_reg;
        bstart_next      = bstart_reg;
        bsize_next       = bsize_reg;
        granted_next     = granted_reg;
        gstart_next      = gstart_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_granted_next = out_granted_reg;
        out_start_next   = out_start_reg;
        seg_we           = 1'b0;
        seg_waddr        = '0;
        seg_wdata        = '0;
        rec_we           = 1'b0;
        rec_waddr        = '0;
        rec_wdata        = '0;

        case (state_reg)
            wfca_pkg::ST_CLEAR:
            begin
                // sweep both RAMs; entry zero gets the whole memory
                if ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(wfca_pkg::SEGMENTS))
                begin
                    seg_we    = 1'b1;
                    seg_waddr = SEG_AW'(clr_cnt_reg);
                    if ((clr_cnt_reg == '0) && (memsize_reg != '0))
                    begin
                        seg_wdata.valid = 1'b1;
                        seg_wdata.start = AW'(1);
                        seg_wdata.len   = memsize_reg;
                    end
                end
                if ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(wfca_pkg::REQUESTS))
                begin
                    rec_we    = 1'b1;
                    rec_waddr = REC_AW'(clr_cnt_reg);
                end
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_W'(wfca_pkg::CLR_DEPTH - 1))
                begin
                    state_next = wfca_pkg::ST_IDLE;
                end
            end
            wfca_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    h_next      = reqcnt_reg;
                    func_next   = req.func;
                    size_next   = req.request_size;
                    handle_next = req.handle;
                    // drop the record of the handle this request takes
                    rec_we      = 1'b1;
                    rec_waddr   = reqcnt_reg;
                    if (reqcnt_reg == REC_AW'(wfca_pkg::REQUESTS - 1))
                    begin
                        reqcnt_next = '0;
                    end
                    else
                    begin
                        reqcnt_next = reqcnt_reg + 1'b1;
                    end
                    state_next = wfca_pkg::ST_REC;
                end
            end
            wfca_pkg::ST_REC:
            begin
                bstart_next   = rec_rdata.start;
                bsize_next    = rec_rdata.size;
                scan_cnt_next = '0;
                if (func_reg && !rec_ok)
                begin
                    state_next = wfca_pkg::ST_IDLE;
                end
                else
                begin
                    if (func_reg)
                    begin
                        rec_we    = 1'b1;
                        rec_waddr = REC_AW'(handle_reg);
                    end
                    state_next = wfca_pkg::ST_SCAN;
                end
            end
            wfca_pkg::ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == SEG_AW'(wfca_pkg::SEGMENTS - 1))
                begin
                    state_next = wfca_pkg::ST_DRAIN;
                end
            end
            wfca_pkg::ST_DRAIN:
            begin
                state_next = wfca_pkg::ST_WB1;
            end
            wfca_pkg::ST_WB1:
            begin
                if (func_reg)
                begin
                    seg_wdata.valid = 1'b1;
                    seg_wdata.start = merged_start;
                    seg_wdata.len   = merged_len[AW-1:0];
                    if (scan_res.left_found)
                    begin
                        seg_we    = 1'b1;
                        seg_waddr = scan_res.left_idx;
                    end
                    else if (scan_res.right_found)
                    begin
                        seg_we    = 1'b1;
                        seg_waddr = scan_res.right_idx;
                    end
                    else if (scan_res.slot_found)
                    begin
                        seg_we    = 1'b1;
                        seg_waddr = scan_res.slot_idx;
                    end
                    state_next = wfca_pkg::ST_WB2;
                end
                else
                begin
                    granted_next = alloc_ok;
                    gstart_next  = alloc_ok ? scan_res.best_start : '0;
                    if (alloc_ok)
                    begin
                        // trim the winner from its front, drop it when used up
                        seg_we    = 1'b1;
                        seg_waddr = scan_res.best_idx;
                        if (scan_res.best_len != size_reg)
                        begin
                            seg_wdata.valid = 1'b1;
                            seg_wdata.start = scan_res.best_start + size_reg;
                            seg_wdata.len   = scan_res.best_len - size_reg;
                        end
                        rec_we          = 1'b1;
                        rec_waddr       = h_reg;
                        rec_wdata.valid = 1'b1;
                        rec_wdata.start = scan_res.best_start;
                        rec_wdata.size  = size_reg;
                    end
                    state_next = wfca_pkg::ST_DONE;
                end
            end
            wfca_pkg::ST_WB2:
            begin
                // right neighbor is absorbed into the left one
                if (scan_res.left_found && scan_res.right_found)
                begin
                    seg_we    = 1'b1;
                    seg_waddr = scan_res.right_idx;
                end
                state_next = wfca_pkg::ST_IDLE;
            end
            wfca_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = granted_reg;
                    out_start_next   = gstart_reg;
                    state_next       = wfca_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wfca_pkg::ST_IDLE;
            end
        endcase

        if (cfg.valid)
        begin
            state_next   = wfca_pkg::ST_CLEAR;
            clr_cnt_next = '0;
            reqcnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wfca_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            scan_cnt_reg  <= '0;
            feed_reg      <= 1'b0;
            reqcnt_reg    <= '0;
            memsize_reg   <= wfca_pkg::MEM_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            scan_cnt_reg  <= scan_cnt_next;
            feed_reg      <= (state_reg == wfca_pkg::ST_SCAN);
            reqcnt_reg    <= reqcnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                memsize_reg <= cfg.memory_size;
            end
        end
    end

    // Payload registers hold without reset.
    always_ff @(posedge clk)
    begin
        feed_idx_reg    <= scan_cnt_reg;
        h_reg           <= h_next;
        func_reg        <= func_next;
        size_reg        <= size_next;
        handle_reg      <= handle_next;
        bstart_reg      <= bstart_next;
        bsize_reg       <= bsize_next;
        granted_reg     <= granted_next;
        gstart_reg      <= gstart_next;
        out_granted_reg <= out_granted_next;
        out_start_reg   <= out_start_next;
    end

    `WFCA_ASSERT_IMP(a_grant_nonzero, clk, rst_n, rsp.valid && rsp.granted, rsp.start_address != '0, "granted block at cell zero")
    `WFCA_ASSERT_IMP(a_fail_zero, clk, rst_n, rsp.valid && !rsp.granted, rsp.start_address == '0, "failed allocate with nonzero address")
    `WFCA_ASSERT_IMP(a_rsp_from_done, clk, rst_n, $rose(out_valid_reg), $past(state_reg == wfca_pkg::ST_DONE), "response outside completion")
    `WFCA_ASSERT_NEXT(a_no_write_in_scan, clk, rst_n, seg_we, state_reg != wfca_pkg::ST_SCAN, "segment write lands in a scan")

endmodule

[sv/wfca_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfca_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module wfca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/wfca_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfca_scan
// Fold one segment entry per cycle while feed is set into the largest, neighbor and free slot.
// ----------------------------------------------------------------------------
module wfca_scan (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wfca_pkg::scan_ctl_t         ctl,
    input  wfca_pkg::seg_word_t         entry,
    input  logic [wfca_pkg::AW:0]       bstart,
    input  logic [wfca_pkg::AW:0]       bend,
    output wfca_pkg::scan_res_t         res
);

    wfca_pkg::scan_res_t res_reg;
    wfca_pkg::scan_res_t res_next;
    logic [wfca_pkg::AW:0] seg_end;
    logic                  better;

    assign res = res_reg;

    always_comb
    begin
        res_next = res_reg;
        seg_end  = {1'b0, entry.start} + {1'b0, entry.len};
        better   = !res_reg.best_found || (entry.len > res_reg.best_len) ||
                   ((entry.len == res_reg.best_len) && (entry.start < res_reg.best_start));
        if (ctl.clear)
        begin
            res_next = '0;
        end
        else if (ctl.feed)
        begin
            if (entry.valid)
            begin
                if (better)
                begin
                    res_next.best_found = 1'b1;
                    res_next.best_idx   = ctl.idx;
                    res_next.best_start = entry.start;
                    res_next.best_len   = entry.len;
                end
                // last match wins on both sides
                if (seg_end == bstart)
                begin
                    res_next.left_found = 1'b1;
                    res_next.left_idx   = ctl.idx;
                    res_next.left_start = entry.start;
                    res_next.left_len   = entry.len;
                end
                if ({1'b0, entry.start} == bend)
                begin
                    res_next.right_found = 1'b1;
                    res_next.right_idx   = ctl.idx;
                    res_next.right_len   = entry.len;
                end
            end
            else if (!res_reg.slot_found)
            begin
                res_next.slot_found = 1'b1;
                res_next.slot_idx   = ctl.idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

endmodule
